// ===== rtl/wlv_pkg.sv =====
package wlv_pkg;

	localparam int unsigned VID_W      = 20;
	localparam int unsigned LABEL_W    = 3;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned PROD_W     = CNT_W + GAIN_W;
	localparam int unsigned CFG_IDX_W  = 4;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;   // 1.0 in Q2.14
	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/weighted_label_vote_core.sv =====
// Weighted label vote: takes a vertex's neighbor labels one word at a time and
// counts them per partition (saturating at 65535). A word with last_neighbor
// set closes the vertex: a single shared 16x16 multiplier then walks the
// partitions one per cycle, forming count * gain (Q2.14), and a registered
// compare keeps the highest nonzero-count score, ties going to the lower label.
// If no neighbor was counted the old label is kept. A word without
// last_neighbor is taken with no stall; a last word holds item_stall high
// through the multiply slots (one per partition), the drain of the compare
// stage and the handoff to the result register, and for as long as the result
// register stays stalled. The result register sits between the vote logic and
// the result channel, so the next vertex may start while a result waits.
// Gains are written through cfg_* (index 0..7), which is always ready; indexes
// at or above NUM_PARTS are ignored.
module weighted_label_vote_core #(
	parameter int unsigned NUM_PARTS = 8   // 2..8
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// neighbor word channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [wlv_pkg::VID_W-1:0]      vertex_id,
	input  logic [wlv_pkg::LABEL_W-1:0]    prev_label,
	input  logic [wlv_pkg::LABEL_W-1:0]    neighbor_label,
	input  logic                           neighbor_valid,
	input  logic                           last_neighbor,

	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [wlv_pkg::VID_W-1:0]      out_vertex_id,
	output logic [wlv_pkg::LABEL_W-1:0]    new_label,
	output logic                           label_changed,

	// gain register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wlv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlv_pkg::GAIN_W-1:0]     cfg_data
);

	localparam int unsigned IDX_W = $clog2(NUM_PARTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PARTS - 1);

	wlv_pkg::state_t state_q, state_nxt;

	logic [wlv_pkg::CNT_W-1:0]   cnt_q  [NUM_PARTS];
	logic [wlv_pkg::GAIN_W-1:0]  gain_q [NUM_PARTS];

	logic [IDX_W-1:0]            scan_idx_q;
	logic [wlv_pkg::PROD_W-1:0]  prod_s1;
	logic [wlv_pkg::LABEL_W-1:0] prod_lbl_s1;
	logic                        prod_nz_s1;
	logic                        prod_vld_s1;

	logic [wlv_pkg::PROD_W-1:0]  top_score_q;
	logic [wlv_pkg::LABEL_W-1:0] best_lbl_q;
	logic                        found_q;
	logic [wlv_pkg::VID_W-1:0]   vid_q;
	logic [wlv_pkg::LABEL_W-1:0] old_q;

	logic                        res_valid_q;
	logic [wlv_pkg::VID_W-1:0]   res_vid_q;
	logic [wlv_pkg::LABEL_W-1:0] res_lbl_q;
	logic                        res_chg_q;

	logic item_acc;
	logic close_vtx;     // last word accepted this cycle
	logic scan_issue;    // multiplier slot active
	logic out_free;      // result register can take a new word
	logic handoff;       // vote done and result register loaded
	logic better;

	assign item_acc  = item_valid && !item_stall;
	assign close_vtx = item_acc && last_neighbor;
	assign out_free  = !res_valid_q || !res_stall;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wlv_pkg::ST_COLLECT: begin
				if (close_vtx) state_nxt = wlv_pkg::ST_SCAN;
			end
			wlv_pkg::ST_SCAN: begin
				if (scan_idx_q == IDX_LAST) state_nxt = wlv_pkg::ST_DRAIN;
			end
			wlv_pkg::ST_DRAIN: begin
				state_nxt = wlv_pkg::ST_DONE;
			end
			wlv_pkg::ST_DONE: begin
				if (out_free) state_nxt = wlv_pkg::ST_COLLECT;
			end
			default: state_nxt = wlv_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		scan_issue = 1'b0;
		handoff    = 1'b0;
		unique case (state_q)
			wlv_pkg::ST_COLLECT: item_stall = 1'b0;
			wlv_pkg::ST_SCAN:    scan_issue = 1'b1;
			wlv_pkg::ST_DRAIN:   ;
			wlv_pkg::ST_DONE:    handoff = out_free;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wlv_pkg::ST_COLLECT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// scan pointer: restarts at partition 0 for every vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (close_vtx) begin
			scan_idx_q <= '0;
		end else if (scan_issue && scan_idx_q != IDX_LAST) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// ---------------------------------------------------------------- histogram
	// each bin watches the word itself; cleared when the result is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARTS; i++) cnt_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_PARTS; i++) begin
				if (handoff) begin
					cnt_q[i] <= '0;
				end else if (item_acc && neighbor_valid &&
				             neighbor_label == wlv_pkg::LABEL_W'(i) &&
				             cnt_q[i] != wlv_pkg::CNT_MAX) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- gains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARTS; i++) gain_q[i] <= wlv_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_PARTS; i++) begin
				if (cfg_index == wlv_pkg::CFG_IDX_W'(i)) gain_q[i] <= cfg_data;
			end
		end
	end

	// ---------------------------------------------------------------- multiply
	// shared multiplier, one partition per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			prod_s1     <= wlv_pkg::PROD_W'(cnt_q[scan_idx_q]) *
			               wlv_pkg::PROD_W'(gain_q[scan_idx_q]);
			prod_nz_s1  <= cnt_q[scan_idx_q] != '0;
			prod_lbl_s1 <= wlv_pkg::LABEL_W'(scan_idx_q);
		end
	end

	// ---------------------------------------------------------------- compare
	// strict greater-than with ascending scan keeps the lowest label on ties
	assign better = prod_vld_s1 && prod_nz_s1 && (!found_q || prod_s1 > top_score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (close_vtx) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (close_vtx) begin
			vid_q      <= vertex_id;
			old_q      <= prev_label;
			best_lbl_q <= prev_label;
		end else if (better) begin
			best_lbl_q  <= prod_lbl_s1;
			top_score_q <= prod_s1;
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (handoff) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			res_vid_q <= vid_q;
			res_lbl_q <= best_lbl_q;
			res_chg_q <= best_lbl_q != old_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign out_vertex_id = res_vid_q;
	assign new_label     = res_lbl_q;
	assign label_changed = res_chg_q;

endmodule

// ===== tb/weighted_label_vote_core_tb.sv =====
`timescale 1ns / 100ps

// Neighbor words go in through item_*, one vote result per vertex comes out
// through res_*. The gains are loaded through cfg_*. A local model of the vote
// predicts every result, and a monitor checks each result word against the
// oldest prediction in order.
module weighted_label_vote_core_tb;
	import wlv_pkg::*;

	localparam int unsigned NUM_PARTS     = 8;
	// last word: NUM_PARTS multiply slots, compare drain, handoff to result reg
	localparam int unsigned VOTE_LATENCY  = NUM_PARTS + 2;
	localparam int unsigned REG_GAIN_BASE = 0;           // gain_part0 .. gain_part7
	localparam int unsigned REG_UNMAPPED  = NUM_PARTS;   // first index the block ignores
	localparam int unsigned REG_INDEX_TOP = 2**CFG_IDX_W - 1;
	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
	localparam logic [VID_W-1:0]  VID_MAX  = '1;
	localparam int unsigned DIR_ROWS      = 20;
	localparam int unsigned RAND_WORDS    = 1550;
	localparam int unsigned RAND_SEGS     = 6;
	localparam int unsigned DRAIN_LIMIT   = 20000;       // cycles to wait for late results

	typedef enum {GS_RANDOM, GS_ZERO, GS_EXTREME, GS_FULL} gain_set_t;

	typedef struct {
		logic [VID_W-1:0]   vid;
		logic [LABEL_W-1:0] old;
		logic [LABEL_W-1:0] nbr;
		logic               nbr_ok;
		logic               last;
	} nbr_word_t;

	typedef struct {
		logic [VID_W-1:0]   vid;
		logic [LABEL_W-1:0] label;
		logic               changed;
	} vote_res_t;

	// Directed row: one neighbor word, plus a hand-typed result where the
	// answer is obvious. Untyped rows fall back to the model.
	typedef struct {
		nbr_word_t w;
		logic      typed;
		vote_res_t res;
	} dir_row_t;

	// DUT-facing signals. Every input starts at a known value.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic               item_valid     = 1'b0;
	logic               item_stall;
	logic [VID_W-1:0]   vertex_id      = '0;
	logic [LABEL_W-1:0] prev_label     = '0;
	logic [LABEL_W-1:0] neighbor_label = '0;
	logic               neighbor_valid = 1'b0;
	logic               last_neighbor  = 1'b0;

	logic               res_valid;
	logic               res_stall      = 1'b0;
	logic [VID_W-1:0]   out_vertex_id;
	logic [LABEL_W-1:0] new_label;
	logic               label_changed;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data  = '0;

	// Model state: its own gains and histogram, plus the FIFO of predicted results.
	logic [GAIN_W-1:0] gain_q [NUM_PARTS];
	logic [CNT_W-1:0]  tally  [NUM_PARTS];
	vote_res_t         elected_q [$];

	int unsigned errors        = 0;
	int unsigned results_seen  = 0;
	int unsigned words_sent    = 0;
	int unsigned vertices_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	dir_row_t dir_tab [DIR_ROWS];

	weighted_label_vote_core #(
		.NUM_PARTS(NUM_PARTS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.vertex_id     (vertex_id),
		.prev_label    (prev_label),
		.neighbor_label(neighbor_label),
		.neighbor_valid(neighbor_valid),
		.last_neighbor (last_neighbor),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.out_vertex_id (out_vertex_id),
		.new_label     (new_label),
		.label_changed (label_changed),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Vote model. Count the neighbor (saturating). On the last word, score
	// each label that has a nonzero count as count * gain, using the full
	// 32-bit product. The highest score wins, and on a tie the lowest label
	// wins, because the scan runs upward and only a strictly greater score
	// replaces the current best. If nothing was counted, the old label stands.
	// The histogram is cleared once the vertex closes.
	// ------------------------------------------------------------------
	task automatic tally_word(input nbr_word_t w, output logic closes, output vote_res_t r);
		logic [PROD_W-1:0]  score;
		logic [PROD_W-1:0]  top_score;
		logic [LABEL_W-1:0] best;
		logic               found;
		closes = 1'b0;
		r = '{default: '0};
		if (w.nbr_ok && w.nbr < NUM_PARTS && tally[w.nbr] != CNT_MAX)
			tally[w.nbr]++;
		if (!w.last)
			return;
		found     = 1'b0;
		best      = w.old;
		top_score = '0;
		for (int p = 0; p < NUM_PARTS; p++) begin
			if (tally[p] == '0)
				continue;
			// a zero gain still takes part, with a score of zero
			score = PROD_W'(tally[p]) * PROD_W'(gain_q[p]);
			if (!found || score > top_score) begin
				found     = 1'b1;
				top_score = score;
				best      = LABEL_W'(p);
			end
		end
		r.vid     = w.vid;
		r.label   = best;
		r.changed = (best != w.old);
		closes    = 1'b1;
		foreach (tally[p])
			tally[p] = '0;
	endtask

	// ------------------------------------------------------------------
	// Neighbor word driver. Called at a falling edge, and returns at a
	// falling edge. Before presenting a word it may idle some cycles.
	// item_valid stays high from one word to the next when there is no
	// gap, so it gets at most one NBA per step. The word is accepted at the
	// first rising edge with item_stall low. The model is updated at that
	// edge.
	// ------------------------------------------------------------------
	task automatic push_word(input nbr_word_t w, input logic typed, input vote_res_t typed_res);
		logic      closes;
		vote_res_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		vertex_id      <= w.vid;
		prev_label     <= w.old;
		neighbor_label <= w.nbr;
		neighbor_valid <= w.nbr_ok;
		last_neighbor  <= w.last;
		item_valid     <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		tally_word(w, closes, r);
		words_sent++;
		if (closes) begin
			vertices_sent++;
			if (typed)
				elected_q.insert(elected_q.size(), typed_res);
			else
				elected_q.insert(elected_q.size(), r);
		end
		@(negedge clk);
	endtask

	// Write all eight gains, then one index the block must ignore. The
	// ignored write goes last so that an aliasing bug would clobber a gain
	// that is still live. cfg_valid is held high across the whole burst.
	task automatic load_gain_set(input gain_set_t mode);
		logic [GAIN_W-1:0] g [NUM_PARTS];
		int unsigned       idx;
		logic [GAIN_W-1:0] val;
		foreach (g[p]) begin
			case (mode)
				GS_ZERO:  g[p] = '0;
				GS_FULL:  g[p] = GAIN_MAX;
				GS_EXTREME: begin
					case ($urandom_range(0, 3))
						0:       g[p] = '0;
						1:       g[p] = GAIN_MAX;
						2:       g[p] = GAIN_RESET;
						default: g[p] = GAIN_W'(1);
					endcase
				end
				default: begin
					// half near 1.0 so that scores land close together
					if ($urandom_range(0, 1))
						g[p] = GAIN_W'($urandom_range(0, GAIN_MAX));
					else
						g[p] = GAIN_W'($urandom_range(12000, 20000));
				end
			endcase
		end
		for (int n = 0; n <= NUM_PARTS; n++) begin
			if (n < NUM_PARTS) begin
				idx = REG_GAIN_BASE + n;
				val = g[n];
			end else begin
				idx = $urandom_range(REG_UNMAPPED, REG_INDEX_TOP);
				val = GAIN_W'($urandom_range(0, GAIN_MAX));
			end
			cfg_index <= CFG_IDX_W'(idx);
			cfg_data  <= val;
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			if (idx < NUM_PARTS)
				gain_q[idx] = val;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Wait until every predicted result has come back. Then allow for a last
	// word still in flight before the next register write. Anything left
	// over after the bound is a failure.
	task automatic settle();
		int unsigned waited;
		waited = 0;
		while (elected_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (elected_q.size() != 0) begin
			errors++;
			$display("%0t: %0d predicted results never arrived, next vid %h",
			         $time, elected_q.size(), elected_q[0].vid);
			elected_q.delete();
		end
		repeat (VOTE_LATENCY + 4) @(negedge clk);
	endtask

	// One random vertex. Most vertices have small degree and some are wide.
	// A few have zero degree. About half draw their labels from a two-label
	// palette, which makes ties and close votes likely. On words before the
	// last, vid/old are sometimes junk, since only the last word's values
	// count.
	task automatic send_vertex();
		int unsigned        deg;
		logic               zero_deg;
		logic               narrow;
		logic [LABEL_W-1:0] pal_a, pal_b, old;
		logic [VID_W-1:0]   vid;
		nbr_word_t          w;
		vote_res_t          none;
		none     = '{default: '0};
		zero_deg = 1'b0;
		case ($urandom_range(0, 19))
			0: begin
				deg      = $urandom_range(1, 3);
				zero_deg = 1'b1;
			end
			1, 2:    deg = $urandom_range(9, 40);
			default: deg = $urandom_range(1, 6);
		endcase
		narrow = 1'($urandom_range(0, 1));
		pal_a  = LABEL_W'($urandom_range(0, 7));
		pal_b  = LABEL_W'($urandom_range(0, 7));
		vid    = VID_W'($urandom_range(0, VID_MAX));
		old    = (narrow && $urandom_range(0, 1)) ? pal_a : LABEL_W'($urandom_range(0, 7));
		for (int unsigned k = 1; k <= deg; k++) begin
			w.last   = (k == deg);
			w.nbr    = narrow ? ($urandom_range(0, 1) ? pal_a : pal_b)
			                  : LABEL_W'($urandom_range(0, 7));
			w.nbr_ok = zero_deg ? 1'b0 : ($urandom_range(0, 9) != 0);
			if (w.last || $urandom_range(0, 2) != 0) begin
				w.vid = vid;
				w.old = old;
			end else begin
				w.vid = VID_W'($urandom_range(0, VID_MAX));
				w.old = LABEL_W'($urandom_range(0, 7));
			end
			push_word(w, 1'b0, none);
		end
	endtask

	function automatic dir_row_t dir_row(
		input logic [VID_W-1:0]   vid,
		input logic [LABEL_W-1:0] old,
		input logic [LABEL_W-1:0] nbr,
		input logic               ok,
		input logic               last,
		input logic               typed,
		input logic [LABEL_W-1:0] exp_label,
		input logic               exp_chg
	);
		dir_row_t r;
		r.w     = '{vid: vid, old: old, nbr: nbr, nbr_ok: ok, last: last};
		r.typed = typed;
		r.res   = '{vid: vid, label: exp_label, changed: exp_chg};
		return r;
	endfunction

	// Result receiver: random backpressure, changed on the falling edge
	always @(negedge clk)
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// Result checker: each accepted result word is compared with the oldest
	// prediction
	always @(posedge clk) begin : res_check
		vote_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (elected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result vid %h label %0d changed %0b",
				         $time, out_vertex_id, new_label, label_changed);
			end else begin
				want = elected_q.pop_front();
				if (out_vertex_id !== want.vid) begin
					errors++;
					$display("%0t: out_vertex_id expected %h got %h",
					         $time, want.vid, out_vertex_id);
				end
				if (new_label !== want.label) begin
					errors++;
					$display("%0t: new_label (vid %h) expected %0d got %0d",
					         $time, want.vid, want.label, new_label);
				end
				if (label_changed !== want.changed) begin
					errors++;
					$display("%0t: label_changed (vid %h) expected %0b got %0b",
					         $time, want.vid, want.changed, label_changed);
				end
			end
		end
	end

	initial begin : stimulus
		gain_set_t seg_mode [RAND_SEGS];
		int unsigned target;

		seg_mode = '{GS_RANDOM, GS_ZERO, GS_EXTREME, GS_RANDOM, GS_FULL, GS_EXTREME};
		foreach (gain_q[p]) gain_q[p] = GAIN_RESET;
		foreach (tally[p])  tally[p]  = '0;

		// Directed rows, using the reset gains (all 1.0). Rows with last=0
		// return nothing.
		dir_tab = '{
			// zero-degree vertex: old label kept, even a nonzero one
			dir_row(20'd0,    3'd5, 3'd0, 1'b0, 1'b1, 1'b1, 3'd5, 1'b0),
			// top vid, top label
			dir_row(VID_MAX,  3'd7, 3'd7, 1'b1, 1'b1, 1'b1, 3'd7, 1'b0),
			dir_row(20'd1,    3'd3, 3'd0, 1'b1, 1'b1, 1'b1, 3'd0, 1'b1),
			// tie 2 vs 6: lower label wins over the old one
			dir_row(20'hABCDE, 3'd0, 3'd2, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'd3,    3'd6, 3'd6, 1'b1, 1'b1, 1'b1, 3'd2, 1'b1),
			// invalid first neighbor, from a "different" vertex; only the last word's
			// vid/old apply
			dir_row(20'h55555, 3'd1, 3'd1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'd5,    3'd4, 3'd4, 1'b1, 1'b1, 1'b1, 3'd4, 1'b0),
			// plain majority
			dir_row(20'd6,    3'd3, 3'd5, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'd6,    3'd3, 3'd5, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'd6,    3'd3, 3'd3, 1'b1, 1'b1, 1'b1, 3'd5, 1'b1),
			// last word invalid: earlier neighbors still decide
			dir_row(20'd7,    3'd0, 3'd1, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'd7,    3'd0, 3'd7, 1'b0, 1'b1, 1'b1, 3'd1, 1'b1),
			// one of every label: full eight-way tie goes to label 0
			dir_row(20'h80000, 3'd7, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd1, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd2, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd3, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd4, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd5, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd6, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0),
			dir_row(20'h80000, 3'd7, 3'd7, 1'b1, 1'b1, 1'b1, 3'd0, 1'b1)
		};

		// reset: held low from the start, released on a falling edge, never again
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 59;
		foreach (dir_tab[i])
			push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
		item_valid <= 1'b0;
		settle();

		// Random vertices in six segments, each with its own gain set. Pairs of
		// segments switch idling: sender slow / receiver slower, then the
		// reverse, then none.
		for (int seg = 0; seg < RAND_SEGS; seg++) begin
			case (seg / 2)
				0: begin send_idle_pct = 37; recv_idle_pct = 59; end
				1: begin send_idle_pct = 59; recv_idle_pct = 37; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			load_gain_set(seg_mode[seg]);
			target = words_sent + RAND_WORDS / RAND_SEGS;
			while (words_sent < target)
				send_vertex();
			item_valid <= 1'b0;
			settle();
		end

		$display("Run covered %0d neighbor words over %0d vertices, %0d results checked,",
		         words_sent, vertices_sent, results_seen);
		$display("with directed edge cases and %0d gain settings.",
		         RAND_SEGS + 1);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Timeout, set well beyond the slowest legal run
	initial begin
		#(2_000_000);
		$display("%0t: timeout, %0d results still pending", $time, elected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
